### src/ohi_pkg.sv
// ohi_pkg: shared widths, register codes and the sequencer microcode for the
// open-addressing hash insert block
// no dependencies; compiled before every other file
`default_nettype none

package ohi_pkg;

    localparam int TABLE_SIZE = 1024;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 10;
    localparam int COLL_W     = 11;
    localparam int MODE_W     = 2;
    localparam int STEP_W     = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_STEP = 1'd1;

    // probe mode codes; the unused code probes like linear
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_LINEAR;
    localparam logic [STEP_W-1:0] STEP_RESET = 10'd1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_TEST,
        S_WRITE,
        S_FAIL,
        S_DONE
    } step_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_EXHAUSTED,
        C_SLOT_FREE,
        C_OUT_FREE,
        C_CLR_DONE
    } cond_t;

    typedef struct packed {
        cond_t cond;
        step_t go_true;
        step_t go_false;
        logic  mem_rd;
        logic  mem_wr;
        logic  wr_val;
        logic  clr_step;
        logic  in_rdy;
        logic  advance_false;
        logic  set_fail;
        logic  out_load_true;
    } ctrl_t;

    // control store: one word per step
    function automatic ctrl_t ucode(step_t s);
        ctrl_t w;
        w = '{cond: C_ALWAYS, go_true: S_IDLE, go_false: S_IDLE, default: 1'b0};
        unique case (s)
            S_CLEAR:
            begin
                w.cond     = C_CLR_DONE;
                w.go_true  = S_IDLE;
                w.go_false = S_CLEAR;
                w.mem_wr   = 1'b1;
                w.clr_step = 1'b1;
            end
            S_IDLE:
            begin
                w.cond     = C_IN_VALID;
                w.go_true  = S_ADDR;
                w.go_false = S_IDLE;
                w.in_rdy   = 1'b1;
            end
            S_ADDR:
            begin
                w.cond     = C_EXHAUSTED;
                w.go_true  = S_FAIL;
                w.go_false = S_TEST;
                w.mem_rd   = 1'b1;
            end
            S_TEST:
            begin
                w.cond          = C_SLOT_FREE;
                w.go_true       = S_WRITE;
                w.go_false      = S_ADDR;
                w.advance_false = 1'b1;
            end
            S_WRITE:
            begin
                w.go_true  = S_DONE;
                w.go_false = S_DONE;
                w.mem_wr   = 1'b1;
                w.wr_val   = 1'b1;
            end
            S_FAIL:
            begin
                w.go_true  = S_DONE;
                w.go_false = S_DONE;
                w.set_fail = 1'b1;
            end
            S_DONE:
            begin
                w.cond          = C_OUT_FREE;
                w.go_true       = S_IDLE;
                w.go_false      = S_DONE;
                w.out_load_true = 1'b1;
            end
            default:
            begin
                w.go_true  = S_IDLE;
                w.go_false = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### src/ohi_key_if.sv
// ohi_key_if: input channel carrying one key per item
// depends on ohi_pkg for the key width
`default_nettype none

interface ohi_key_if;
    logic                        valid;
    logic                        ready;
    logic [ohi_pkg::KEY_W-1:0]   key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

`default_nettype wire

### src/ohi_res_if.sv
// ohi_res_if: result channel, slot, collision count and failure flag
// depends on ohi_pkg for field widths
`default_nettype none

interface ohi_res_if;
    logic                        valid;
    logic                        ready;
    logic [ohi_pkg::SLOT_W-1:0]  slot;
    logic [ohi_pkg::COLL_W-1:0]  collisions;
    logic                        failed;

    modport source (output valid, output slot, output collisions, output failed, input ready);
    modport sink   (input valid, input slot, input collisions, input failed, output ready);
endinterface

`default_nettype wire

### src/ohi_cfg_if.sv
// ohi_cfg_if: configuration write channel, register index and data
// depends on ohi_pkg for index and data widths
`default_nettype none

interface ohi_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ohi_pkg::CFG_IDX_W-1:0]   index;
    logic [ohi_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/ohi_ram.sv
// ohi_ram: generic single-port RAM with registered read data
// no package dependencies
`default_nettype none

module ohi_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/open_addressing_hash_insert.sv
// open_addressing_hash_insert: inserts keys into an open-addressed occupancy
// table, microcoded sequencer over one occupancy RAM
// depends on ohi_pkg, ohi_key_if, ohi_res_if, ohi_cfg_if, ohi_ram
//
//  channel   dir  payload                          handshake
//  keys      in   key[9:0]                         valid/ready
//  results   out  slot[9:0] collisions[10:0] failed valid/ready
//  cfg       in   index[0] data[9:0]               valid/ready, ready tied high
//
// each probe of an item takes one read and one test through the single occupancy
// RAM port; a failed insert gives up after TABLE_SIZE probes
// after reset the sequencer clears the occupancy RAM with keys held off;
// configuration writes are taken at any time
// the result sits in an output register, so the next key is taken while it waits
`default_nettype none

module open_addressing_hash_insert (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ohi_key_if.sink     keys,
    ohi_res_if.source   results,
    ohi_cfg_if.sink     cfg
);

    localparam int SLOT_W = ohi_pkg::SLOT_W;
    localparam int COLL_W = ohi_pkg::COLL_W;

    ohi_pkg::step_t step_reg, step_next;
    ohi_pkg::ctrl_t ctrl;

    logic [ohi_pkg::MODE_W-1:0] mode_reg;
    logic [ohi_pkg::STEP_W-1:0] dstep_reg;

    logic [SLOT_W-1:0] clr_cnt_reg;
    logic [SLOT_W-1:0] home_reg;
    logic [SLOT_W-1:0] offset_reg, offset_next;
    logic [COLL_W-1:0] probe_reg;
    logic              fail_reg;

    logic              out_valid_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [COLL_W-1:0] out_coll_reg;
    logic              out_fail_reg;

    logic [SLOT_W-1:0] probe_idx;
    logic [SLOT_W-1:0] mem_addr;
    logic              mem_rdata;
    logic              cond_true;
    logic              in_take;
    logic              advance;
    logic              out_load;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ohi_pkg::MODE_RESET;
            dstep_reg <= ohi_pkg::STEP_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ohi_pkg::REG_PROBE_MODE:  mode_reg  <= cfg.data[ohi_pkg::MODE_W-1:0];
                ohi_pkg::REG_DOUBLE_STEP: dstep_reg <= cfg.data[ohi_pkg::STEP_W-1:0];
                default:                  ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        ctrl = ohi_pkg::ucode(step_reg);
    end

    always_comb
    begin
        unique case (ctrl.cond)
            ohi_pkg::C_ALWAYS:    cond_true = 1'b1;
            ohi_pkg::C_IN_VALID:  cond_true = keys.valid;
            ohi_pkg::C_EXHAUSTED: cond_true = (probe_reg == COLL_W'(ohi_pkg::TABLE_SIZE));
            ohi_pkg::C_SLOT_FREE: cond_true = !mem_rdata;
            ohi_pkg::C_OUT_FREE:  cond_true = !out_valid_reg || results.ready;
            ohi_pkg::C_CLR_DONE:  cond_true = (clr_cnt_reg == {SLOT_W{1'b1}});
            default:              cond_true = 1'b1;
        endcase
        step_next = cond_true ? ctrl.go_true : ctrl.go_false;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ohi_pkg::S_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // datapath
    assign in_take   = ctrl.in_rdy && keys.valid;
    assign advance   = ctrl.advance_false && !cond_true;
    assign out_load  = ctrl.out_load_true && cond_true;
    assign probe_idx = home_reg + offset_reg;
    assign mem_addr  = (step_reg == ohi_pkg::S_CLEAR) ? clr_cnt_reg : probe_idx;
    assign keys.ready = ctrl.in_rdy;

    // next probe offset: f(i+1) - f(i) is 1, 2i+1 or the step, all mod table size
    always_comb
    begin
        unique case (mode_reg)
            ohi_pkg::MODE_QUAD:   offset_next = offset_reg + {probe_reg[SLOT_W-2:0], 1'b1};
            ohi_pkg::MODE_DOUBLE: offset_next = offset_reg + SLOT_W'(dstep_reg);
            default:              offset_next = offset_reg + SLOT_W'(1);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            fail_reg    <= 1'b0;
            probe_reg   <= '0;
            offset_reg  <= '0;
        end
        else
        begin
            if (ctrl.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            end
            if (in_take)
            begin
                fail_reg   <= 1'b0;
                probe_reg  <= '0;
                offset_reg <= '0;
            end
            else if (advance)
            begin
                probe_reg  <= probe_reg + COLL_W'(1);
                offset_reg <= offset_next;
            end
            if (ctrl.set_fail)
            begin
                fail_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            home_reg <= keys.key[SLOT_W-1:0];
        end
    end

    ohi_ram #(
        .WIDTH (1),
        .DEPTH (ohi_pkg::TABLE_SIZE)
    ) u_used (
        .clk   (clk),
        .we    (ctrl.mem_wr),
        .re    (ctrl.mem_rd),
        .addr  (mem_addr),
        .wdata (ctrl.wr_val),
        .rdata (mem_rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_slot_reg <= fail_reg ? '0 : probe_idx;
            out_coll_reg <= probe_reg;
            out_fail_reg <= fail_reg;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.slot       = out_slot_reg;
    assign results.collisions = out_coll_reg;
    assign results.failed     = out_fail_reg;

endmodule

`default_nettype wire
